FILE: rtl/core/mfbrd_pkg.sv
// ----------------------------------------------------------------------------
// mfbrd_pkg
// Shared types and constants of the monochrome frame buffer drawing engine.
// ----------------------------------------------------------------------------
package mfbrd_pkg;

  localparam int MODE_W  = 3;
  localparam int COORD_W = 8;
  localparam int IDX_W   = 12;
  localparam int BYTE_W  = 8;
  localparam int SUM_W   = COORD_W + 1;
  localparam int BCOL_W  = SUM_W - 3;

  localparam logic [MODE_W-1:0] MODE_PIXEL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_OUTLINE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FILL    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

  typedef enum logic [1:0] {
    ADDR_DRAW,
    ADDR_CLEAR,
    ADDR_INDEX
  } addr_sel_t;

  typedef struct packed {
    logic      load;
    logic      setup;
    logic      span_load;
    logic      pass_set;
    logic      row_next;
    logic      byte_next;
    logic      clr_start;
    logic      clr_next;
    logic      mem_rd;
    logic      mem_wr;
    addr_sel_t addr_sel;
    logic      res_load;
  } cmd_t;

  typedef struct packed {
    logic is_draw;
    logic is_clear;
    logic is_read;
    logic rows_empty;
    logic span_ok;
    logic mid_row;
    logic pass;
    logic byte_last;
    logic row_last;
    logic clr_last;
  } sts_t;

endpackage

FILE: rtl/core/mfbrd_in_if.sv
// ----------------------------------------------------------------------------
// mfbrd_in_if
// Command channel of the frame buffer drawing engine.
// ----------------------------------------------------------------------------
interface mfbrd_in_if;
  logic                           valid;
  logic                           ready;
  logic [mfbrd_pkg::MODE_W-1:0]   mode;
  logic [mfbrd_pkg::COORD_W-1:0]  x_pos;
  logic [mfbrd_pkg::COORD_W-1:0]  y_pos;
  logic [mfbrd_pkg::COORD_W-1:0]  rect_width;
  logic [mfbrd_pkg::COORD_W-1:0]  rect_height;
  logic                           color;
  logic [mfbrd_pkg::IDX_W-1:0]    byte_index;

  modport source (
    output valid, mode, x_pos, y_pos, rect_width, rect_height, color, byte_index,
    input  ready
  );

  modport sink (
    input  valid, mode, x_pos, y_pos, rect_width, rect_height, color, byte_index,
    output ready
  );
endinterface

FILE: rtl/core/mfbrd_out_if.sv
// ----------------------------------------------------------------------------
// mfbrd_out_if
// Result channel of the frame buffer drawing engine.
// ----------------------------------------------------------------------------
interface mfbrd_out_if;
  logic                          valid;
  logic                          ready;
  logic [mfbrd_pkg::BYTE_W-1:0]  read_byte;
  logic                          done_res;

  modport source (
    output valid, read_byte, done_res,
    input  ready
  );

  modport sink (
    input  valid, read_byte, done_res,
    output ready
  );
endinterface

FILE: rtl/core/mfbrd_datapath.sv
// ----------------------------------------------------------------------------
// mfbrd_datapath
// Command registers, rectangle walk counters, byte masking and the frame store.
// ----------------------------------------------------------------------------
module mfbrd_datapath #(
  parameter int DISPLAY_WIDTH  = 240,
  parameter int DISPLAY_HEIGHT = 128,
  parameter int ROW_BYTES      = 30
) (
  input  logic                            clk,
  input  mfbrd_pkg::cmd_t                 cmd,
  output mfbrd_pkg::sts_t                 sts,
  input  logic [mfbrd_pkg::MODE_W-1:0]    in_mode,
  input  logic [mfbrd_pkg::COORD_W-1:0]   in_x_pos,
  input  logic [mfbrd_pkg::COORD_W-1:0]   in_y_pos,
  input  logic [mfbrd_pkg::COORD_W-1:0]   in_rect_width,
  input  logic [mfbrd_pkg::COORD_W-1:0]   in_rect_height,
  input  logic                            in_color,
  input  logic [mfbrd_pkg::IDX_W-1:0]     in_byte_index,
  output logic [mfbrd_pkg::BYTE_W-1:0]    out_read_byte,
  output logic                            out_done_res
);

  localparam int STORE   = ROW_BYTES * DISPLAY_HEIGHT;
  localparam int AW      = (STORE > 1) ? $clog2(STORE) : 1;
  localparam int COL_MAX = (DISPLAY_WIDTH < ROW_BYTES * 8) ? DISPLAY_WIDTH : ROW_BYTES * 8;
  localparam int CW      = mfbrd_pkg::SUM_W;
  localparam int BW      = mfbrd_pkg::BCOL_W;

  logic [mfbrd_pkg::MODE_W-1:0]  mode_r;
  logic [mfbrd_pkg::COORD_W-1:0] x_r, y_r, w_r, h_r;
  logic                          color_r;
  logic [mfbrd_pkg::IDX_W-1:0]   idx_r;

  logic [CW-1:0] last_col_r, last_row_r, col_lo_r, col_hi_r, row_r, row_end_r;
  logic [CW-1:0] span_lo_r, span_hi_r;
  logic [AW-1:0] row_base_r, clr_addr_r;
  logic [BW-1:0] byte_r, byte_end_r;
  logic          pass_r;
  logic [7:0]    rdata_r;

  logic [7:0] mem [STORE];

  logic [CW-1:0] last_col, last_row, col_lo, col_hi, row_start, row_end;
  logic [CW-1:0] x_ext, span_lo, span_hi, span_lo_m1, span_hi_m1;
  logic [AW-1:0] row_base_calc, addr;
  logic          span_ok, mid_row, idx_ok;
  logic [7:0]    mask, wdata;
  logic [CW:0]   bit_col [8];

  assign x_ext     = {1'b0, x_r};
  assign last_col  = x_ext + {1'b0, w_r} - CW'(1);
  assign last_row  = {1'b0, y_r} + {1'b0, h_r} - CW'(1);
  assign col_lo    = (x_r == '0) ? CW'(1) : x_ext;
  assign col_hi    = (int'(last_col) > COL_MAX) ? CW'(COL_MAX) : last_col;
  assign row_start = (y_r == '0) ? CW'(1) : {1'b0, y_r};
  assign row_end   = (int'(last_row) > DISPLAY_HEIGHT) ? CW'(DISPLAY_HEIGHT) : last_row;
  assign row_base_calc = AW'(ROW_BYTES * int'(row_start - CW'(1)));
  assign idx_ok    = int'(idx_r) < STORE;

  assign mid_row = (mode_r == mfbrd_pkg::MODE_OUTLINE) && (row_r != {1'b0, y_r}) &&
                   (row_r != last_row_r);

  always_comb begin
    if (!mid_row) begin
      span_lo = col_lo_r;
      span_hi = col_hi_r;
      span_ok = col_lo_r <= col_hi_r;
    end else if (!pass_r) begin
      span_lo = x_ext;
      span_hi = x_ext;
      span_ok = (x_r != '0) && (int'(x_r) <= COL_MAX);
    end else begin
      span_lo = last_col_r;
      span_hi = last_col_r;
      span_ok = (last_col_r != '0) && (int'(last_col_r) <= COL_MAX);
    end
  end

  assign span_lo_m1 = span_lo - CW'(1);
  assign span_hi_m1 = span_hi - CW'(1);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      bit_col[k] = {1'b0, byte_r, 3'(k)} + (CW + 1)'(1);
      mask[k]    = (bit_col[k] >= {1'b0, span_lo_r}) && (bit_col[k] <= {1'b0, span_hi_r});
    end
  end

  assign wdata = color_r ? (rdata_r | mask) : (rdata_r & ~mask);

  always_comb begin
    case (cmd.addr_sel)
      mfbrd_pkg::ADDR_DRAW:  addr = row_base_r + AW'(byte_r);
      mfbrd_pkg::ADDR_CLEAR: addr = clr_addr_r;
      mfbrd_pkg::ADDR_INDEX: addr = AW'(idx_r);
      default:               addr = clr_addr_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[addr] <= (cmd.addr_sel == mfbrd_pkg::ADDR_CLEAR) ? 8'd0 : wdata;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      x_r     <= in_x_pos;
      y_r     <= in_y_pos;
      w_r     <= (in_mode == mfbrd_pkg::MODE_PIXEL) ? 8'd1 : in_rect_width;
      h_r     <= (in_mode == mfbrd_pkg::MODE_PIXEL) ? 8'd1 : in_rect_height;
      color_r <= in_color;
      idx_r   <= in_byte_index;
    end
    if (cmd.setup) begin
      last_col_r <= last_col;
      last_row_r <= last_row;
      col_lo_r   <= col_lo;
      col_hi_r   <= col_hi;
      row_r      <= row_start;
      row_end_r  <= row_end;
      row_base_r <= row_base_calc;
      pass_r     <= 1'b0;
    end
    if (cmd.span_load) begin
      span_lo_r  <= span_lo;
      span_hi_r  <= span_hi;
      byte_r     <= span_lo_m1[CW-1:3];
      byte_end_r <= span_hi_m1[CW-1:3];
    end
    if (cmd.byte_next) begin
      byte_r <= byte_r + BW'(1);
    end
    if (cmd.pass_set) begin
      pass_r <= 1'b1;
    end
    if (cmd.row_next) begin
      row_r      <= row_r + CW'(1);
      row_base_r <= row_base_r + AW'(ROW_BYTES);
      pass_r     <= 1'b0;
    end
    if (cmd.clr_start) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_next) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
    if (cmd.res_load) begin
      out_read_byte <= ((mode_r == mfbrd_pkg::MODE_READ) && idx_ok) ? rdata_r : 8'd0;
      out_done_res  <= 1'b1;
    end
  end

  always_comb begin
    sts.is_draw    = ((mode_r == mfbrd_pkg::MODE_PIXEL) || (mode_r == mfbrd_pkg::MODE_OUTLINE) ||
                      (mode_r == mfbrd_pkg::MODE_FILL)) && (w_r != '0) && (h_r != '0);
    sts.is_clear   = mode_r == mfbrd_pkg::MODE_CLEAR;
    sts.is_read    = mode_r == mfbrd_pkg::MODE_READ;
    sts.rows_empty = row_r > row_end_r;
    sts.span_ok    = span_ok;
    sts.mid_row    = mid_row;
    sts.pass       = pass_r;
    sts.byte_last  = byte_r == byte_end_r;
    sts.row_last   = row_r == row_end_r;
    sts.clr_last   = clr_addr_r == AW'(STORE - 1);
  end

endmodule

FILE: rtl/core/mfbrd_ctrl.sv
// ----------------------------------------------------------------------------
// mfbrd_ctrl
// Sequencer that walks commands through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module mfbrd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output mfbrd_pkg::cmd_t  cmd,
  input  mfbrd_pkg::sts_t  sts
);

  typedef enum logic [3:0] {
    S_BOOT,
    S_INIT_CLR,
    S_IDLE,
    S_DECODE,
    S_CLR,
    S_ROW,
    S_RD,
    S_WR,
    S_NEXT,
    S_RDB,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.addr_sel  = mfbrd_pkg::ADDR_DRAW;
    case (state_r)
      S_BOOT: begin
        cmd.clr_start = 1'b1;
        state_nxt     = S_INIT_CLR;
      end
      S_INIT_CLR: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = mfbrd_pkg::ADDR_CLEAR;
        cmd.clr_next = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_clear) begin
          cmd.clr_start = 1'b1;
          state_nxt     = S_CLR;
        end else if (sts.is_read) begin
          state_nxt = S_RDB;
        end else if (sts.is_draw) begin
          cmd.setup = 1'b1;
          state_nxt = S_ROW;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_CLR: begin
        cmd.mem_wr   = 1'b1;
        cmd.addr_sel = mfbrd_pkg::ADDR_CLEAR;
        cmd.clr_next = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_RESP;
        end
      end
      S_ROW: begin
        if (sts.rows_empty) begin
          state_nxt = S_RESP;
        end else if (sts.span_ok) begin
          cmd.span_load = 1'b1;
          state_nxt     = S_RD;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = S_WR;
      end
      S_WR: begin
        cmd.mem_wr = 1'b1;
        if (sts.byte_last) begin
          state_nxt = S_NEXT;
        end else begin
          cmd.byte_next = 1'b1;
          state_nxt     = S_RD;
        end
      end
      S_NEXT: begin
        if (sts.mid_row && !sts.pass) begin
          cmd.pass_set = 1'b1;
          state_nxt    = S_ROW;
        end else if (sts.row_last) begin
          state_nxt = S_RESP;
        end else begin
          cmd.row_next = 1'b1;
          state_nxt    = S_ROW;
        end
      end
      S_RDB: begin
        cmd.mem_rd   = 1'b1;
        cmd.addr_sel = mfbrd_pkg::ADDR_INDEX;
        state_nxt    = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_BOOT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/mono_framebuffer_rect_draw_unit.sv
// ----------------------------------------------------------------------------
// mono_framebuffer_rect_draw_unit
// One-bit-per-pixel frame store with pixel, rectangle, clear and read commands.
// ----------------------------------------------------------------------------
// The unit takes one command at a time and gives one result per command. The
// frame store is a single-port memory of ROW_BYTES*DISPLAY_HEIGHT bytes, and
// every pixel change is a read-modify-write of one byte. A rectangle is drawn
// as a read and a write for each store byte it touches on each row, with row
// bookkeeping for each pass over a row (an outline side row takes one pass per
// edge column) and command decode and response states around the walk. Clear
// walks the whole store at one byte per cycle, and a byte read is one store
// read followed by the response. After reset the same clearing pass runs
// before the first command is taken. A new command is taken while the
// previous result still waits on the result channel.
module mono_framebuffer_rect_draw_unit #(
  parameter int DISPLAY_WIDTH  = 240,
  parameter int DISPLAY_HEIGHT = 128,
  parameter int ROW_BYTES      = 30
) (
  input  logic         clk,
  input  logic         rst_n,
  mfbrd_in_if.sink     in_chan,
  mfbrd_out_if.source  out_chan
);

  mfbrd_pkg::cmd_t cmd;
  mfbrd_pkg::sts_t sts;
  logic            in_ready;
  logic            out_valid;

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

  mfbrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  mfbrd_datapath #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .ROW_BYTES      (ROW_BYTES)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .in_mode        (in_chan.mode),
    .in_x_pos       (in_chan.x_pos),
    .in_y_pos       (in_chan.y_pos),
    .in_rect_width  (in_chan.rect_width),
    .in_rect_height (in_chan.rect_height),
    .in_color       (in_chan.color),
    .in_byte_index  (in_chan.byte_index),
    .out_read_byte  (out_chan.read_byte),
    .out_done_res   (out_chan.done_res)
  );

endmodule

FILE: rtl/core/mfbrd_checker.sv
// ----------------------------------------------------------------------------
// mfbrd_checker
// Port-level checks of the frame buffer drawing engine, bound to the top level.
// ----------------------------------------------------------------------------
module mfbrd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mfbrd_pkg::BYTE_W-1:0]  out_read_byte,
  input logic                          out_done_res
);

  // Every result marks a finished command.
  a_done_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_done_res)
    else $error("result shown without done flag");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_byte))
    else $error("stalled result changed");

  // The unit is not ready again in the cycle after it takes a command.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken on consecutive cycles");

  // The store is being cleared right after reset, so no command is taken.
  a_no_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or result right after reset");

endmodule

bind mono_framebuffer_rect_draw_unit mfbrd_checker u_mfbrd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_read_byte (out_chan.read_byte),
  .out_done_res  (out_chan.done_res)
);
